[rtl/audio_frame_ring_drop_oldest_unit_assert.svh]
// Assertion macros used by the ring buffer top module.
// Each macro expects signals named clk and arst_n in the using scope.
`ifndef AUDIO_FRAME_RING_DROP_OLDEST_UNIT_ASSERT_SVH
`define AUDIO_FRAME_RING_DROP_OLDEST_UNIT_ASSERT_SVH

// Same-cycle implication.
`define AFR_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("afr: same-cycle check failed");

// Implication whose consequent starts in the cycle after the antecedent.
`define AFR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("afr: next-cycle check failed");

`endif

[rtl/afr_pkg.sv]
`timescale 1ns / 1ps

package afr_pkg;

	localparam int RING_FRAMES = 16384;
	localparam int POS_W       = $clog2(RING_FRAMES);
	localparam int FILL_W      = $clog2(RING_FRAMES + 1);
	localparam int WAIT_W      = 15;
	localparam int TOTAL_W     = 64;
	localparam int FRAME_W     = 32;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int FRAME_BYTES = 4;

	typedef logic [POS_W-1:0]   pos_t;
	typedef logic [FILL_W-1:0]  fill_t;
	typedef logic [TOTAL_W-1:0] total_t;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_READ  = 1'b1
	} op_t;

	typedef struct packed {
		op_t                op;
		logic signed [15:0] left_in;
		logic signed [15:0] right_in;
	} cmd_t;

	typedef struct packed {
		logic signed [15:0] left_out;
		logic signed [15:0] right_out;
		logic               frame_valid;
		logic               overrun;
		logic [WAIT_W-1:0]  frames_waiting;
		total_t             bytes_written_total;
		total_t             bytes_read_total;
		total_t             loud_total;
	} result_t;

	// One classified item on its way from the front to the back.
	typedef struct packed {
		op_t                kind;
		logic               hit;
		logic               overrun;
		logic [1:0]         loud_inc;
		pos_t               addr;
		logic [FRAME_W-1:0] frame;
		fill_t              fill;
	} entry_t;

	function automatic pos_t advance(pos_t p);
		return (p == POS_W'(RING_FRAMES - 1)) ? '0 : p + POS_W'(1);
	endfunction

endpackage

[rtl/afr_ram.sv]
`timescale 1ns / 1ps

module afr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/afr_queue.sv]
`timescale 1ns / 1ps

module afr_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  afr_pkg::entry_t push_entry,
	output logic            full,
	input  logic            pop,
	output logic            not_empty,
	output afr_pkg::entry_t head
);

	afr_pkg::entry_t                slot_q [afr_pkg::QUEUE_DEPTH];
	logic [afr_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [afr_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [afr_pkg::QCNT_W-1:0]     count_q;
	logic                           do_push;
	logic                           do_pop;

	function automatic logic [afr_pkg::QPTR_W-1:0] bump(logic [afr_pkg::QPTR_W-1:0] p);
		return (p == afr_pkg::QPTR_W'(afr_pkg::QUEUE_DEPTH - 1)) ?
			'0 : p + afr_pkg::QPTR_W'(1);
	endfunction

	assign full      = (count_q == afr_pkg::QCNT_W'(afr_pkg::QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign head      = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + afr_pkg::QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - afr_pkg::QCNT_W'(1);
			end
		end
	end

endmodule

[rtl/afr_front.sv]
`timescale 1ns / 1ps

module afr_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  afr_pkg::cmd_t   cmd,
	output logic            busy,
	input  logic            queue_full,
	output logic            push,
	output afr_pkg::entry_t push_entry
);

	afr_pkg::pos_t  wr_pos_q;
	afr_pkg::pos_t  rd_pos_q;
	afr_pkg::fill_t fill_q;
	afr_pkg::pos_t  wr_pos_d;
	afr_pkg::pos_t  rd_pos_d;
	afr_pkg::fill_t fill_d;
	logic           ring_full;

	assign busy      = queue_full;
	assign push      = start && !queue_full;
	assign ring_full = (fill_q == afr_pkg::FILL_W'(afr_pkg::RING_FRAMES));

	// Ring positions and the fill level are settled here, so the back end
	// only has to carry out the memory access and keep the totals.
	always_comb begin
		wr_pos_d            = wr_pos_q;
		rd_pos_d            = rd_pos_q;
		fill_d              = fill_q;
		push_entry.kind     = cmd.op;
		push_entry.hit      = 1'b0;
		push_entry.overrun  = 1'b0;
		push_entry.loud_inc = {1'b0, cmd.left_in != '0} + {1'b0, cmd.right_in != '0};
		push_entry.addr     = rd_pos_q;
		push_entry.frame    = {cmd.right_in, cmd.left_in};
		unique case (cmd.op)
			afr_pkg::OP_WRITE: begin
				push_entry.addr = wr_pos_q;
				wr_pos_d        = afr_pkg::advance(wr_pos_q);
				if (ring_full) begin
					// The oldest frame is dropped; the level stays at capacity.
					rd_pos_d           = afr_pkg::advance(rd_pos_q);
					push_entry.overrun = 1'b1;
				end else begin
					fill_d = fill_q + afr_pkg::FILL_W'(1);
				end
			end
			afr_pkg::OP_READ: begin
				if (fill_q != '0) begin
					push_entry.hit = 1'b1;
					rd_pos_d       = afr_pkg::advance(rd_pos_q);
					fill_d         = fill_q - afr_pkg::FILL_W'(1);
				end
			end
			default: begin
			end
		endcase
		push_entry.fill = fill_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_pos_q <= '0;
			rd_pos_q <= '0;
			fill_q   <= '0;
		end else if (push) begin
			wr_pos_q <= wr_pos_d;
			rd_pos_q <= rd_pos_d;
			fill_q   <= fill_d;
		end
	end

endmodule

[rtl/afr_back.sv]
`timescale 1ns / 1ps

module afr_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             not_empty,
	input  afr_pkg::entry_t  head,
	output logic             pop,
	output logic             done,
	output afr_pkg::result_t result
);

	logic                        valid_s1;
	afr_pkg::entry_t             meta_s1;
	logic [afr_pkg::FRAME_W-1:0] rdata;
	logic                        ram_we;
	logic                        ram_re;
	afr_pkg::total_t             wr_bytes_q;
	afr_pkg::total_t             rd_bytes_q;
	afr_pkg::total_t             loud_q;
	afr_pkg::total_t             wr_bytes_d;
	afr_pkg::total_t             rd_bytes_d;
	afr_pkg::total_t             loud_d;
	logic                        is_write_s1;
	logic                        done_q;
	afr_pkg::result_t            result_q;
	afr_pkg::result_t            result_d;

	// The back end never stalls: one memory access per cycle.
	assign pop    = not_empty;
	assign ram_we = pop && (head.kind == afr_pkg::OP_WRITE);
	assign ram_re = pop && head.hit;

	afr_ram #(
		.WIDTH(afr_pkg::FRAME_W),
		.DEPTH(afr_pkg::RING_FRAMES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(head.addr),
		.wdata(head.frame),
		.re   (ram_re),
		.raddr(head.addr),
		.rdata(rdata)
	);

	always_ff @(posedge clk) begin
		if (pop) begin
			meta_s1 <= head;
		end
		if (valid_s1) begin
			result_q <= result_d;
		end
	end

	assign is_write_s1 = (meta_s1.kind == afr_pkg::OP_WRITE);

	always_comb begin
		wr_bytes_d = wr_bytes_q;
		rd_bytes_d = rd_bytes_q;
		loud_d     = loud_q;
		if (is_write_s1) begin
			wr_bytes_d = wr_bytes_q + afr_pkg::TOTAL_W'(afr_pkg::FRAME_BYTES);
			loud_d     = loud_q + afr_pkg::TOTAL_W'(meta_s1.loud_inc);
		end
		if (meta_s1.hit) begin
			rd_bytes_d = rd_bytes_q + afr_pkg::TOTAL_W'(afr_pkg::FRAME_BYTES);
		end
		result_d.left_out            = meta_s1.hit ? rdata[15:0] : '0;
		result_d.right_out           = meta_s1.hit ? rdata[31:16] : '0;
		result_d.frame_valid         = meta_s1.hit;
		result_d.overrun             = meta_s1.overrun;
		result_d.frames_waiting      = afr_pkg::WAIT_W'(meta_s1.fill);
		result_d.bytes_written_total = wr_bytes_d;
		result_d.bytes_read_total    = rd_bytes_d;
		result_d.loud_total          = loud_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			done_q     <= 1'b0;
			wr_bytes_q <= '0;
			rd_bytes_q <= '0;
			loud_q     <= '0;
		end else begin
			valid_s1 <= pop;
			done_q   <= valid_s1;
			if (valid_s1) begin
				wr_bytes_q <= wr_bytes_d;
				rd_bytes_q <= rd_bytes_d;
				loud_q     <= loud_d;
			end
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

[rtl/audio_frame_ring_drop_oldest_unit.sv]
`timescale 1ns / 1ps
`include "audio_frame_ring_drop_oldest_unit_assert.svh"

// Stereo audio frame ring of afr_pkg::RING_FRAMES entries that overwrites the
// oldest frame when full. An item is taken at a rising edge with start high
// and busy low; cmd.op selects a frame write or a frame read. Every item
// yields exactly one result, shown on result for a single cycle with done
// high, once it has passed the queue, the back-end s1 stage and the result
// register. The receiver cannot stall, so it must capture result whenever
// done is high. The block takes one item per cycle without pause: the frame
// memory in the back end serves one access per cycle, and the back end
// drains one entry of the two-entry queue between the front end and the
// back end every cycle, so that queue never fills and busy stays low. Reads
// of an empty ring return silence with frame_valid low, and a write into a
// full ring drops the oldest frame and raises overrun. The byte and
// loud-sample totals are 64-bit counters that wrap.

module audio_frame_ring_drop_oldest_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  afr_pkg::cmd_t    cmd,
	output logic             done,
	output afr_pkg::result_t result
);

	// Front end: takes items, tracks ring positions and fill level, and
	// classifies each item as a store, a hit read, a miss read or an overrun.
	logic            push;
	afr_pkg::entry_t push_entry;
	logic            queue_full;

	// Back end: does the memory access and keeps the running totals.
	logic            pop;
	logic            not_empty;
	afr_pkg::entry_t head;
	logic            accept;

	assign accept = start && !busy;

	afr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cmd       (cmd),
		.busy      (busy),
		.queue_full(queue_full),
		.push      (push),
		.push_entry(push_entry)
	);

	afr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.full      (queue_full),
		.pop       (pop),
		.not_empty (not_empty),
		.head      (head)
	);

	afr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.not_empty(not_empty),
		.head     (head),
		.pop      (pop),
		.done     (done),
		.result   (result)
	);

	// Every accepted item produces its result: done is seen high once the item
	// has passed the queue, the back-end s1 stage and the result register.
	`AFR_ASSERT_NEXT(a_accept_gives_result, accept, ##2 done)
	// A write that dropped a frame leaves the ring exactly at capacity.
	`AFR_ASSERT_NOW(a_overrun_at_capacity, done && result.overrun,
		result.frames_waiting == afr_pkg::WAIT_W'(afr_pkg::RING_FRAMES))
	// A frame read out and a dropped frame never come from the same item, and a read leaves the ring below capacity.
	`AFR_ASSERT_NOW(a_valid_excludes_overrun, done && result.frame_valid,
		!result.overrun && (result.frames_waiting != afr_pkg::WAIT_W'(afr_pkg::RING_FRAMES)))

endmodule
